// ===== hdl/sorted_insert_drop_max_defines.svh =====
// assertion macros shared by the sorted insert block
`ifndef SORTED_INSERT_DROP_MAX_DEFINES_SVH
`define SORTED_INSERT_DROP_MAX_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define SIDM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define SIDM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/sidm_pkg.sv =====
// shared constants and types for the sorted insert block
`default_nettype none

package sidm_pkg;

	// table geometry and field widths
	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int IDX_W  = 4;
	localparam int KIND_W = 2;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// item kinds
	localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

	// control sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_SWEEP
	} state_t;

	// per-cell commands for the current cycle
	typedef struct packed {
		logic load;
		logic shift;
		logic place;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/sidm_cell.sv =====
// one table cell: entry register plus running min/max stage
`default_nettype none

`include "sorted_insert_drop_max_defines.svh"

module sidm_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sidm_pkg::cell_ctrl_t                ctrl,
	input  logic signed [sidm_pkg::DATA_W-1:0]  value_in,
	input  logic signed [sidm_pkg::DATA_W-1:0]  left_entry,
	input  logic signed [sidm_pkg::DATA_W-1:0]  left_min,
	input  logic signed [sidm_pkg::DATA_W-1:0]  left_max,
	output logic signed [sidm_pkg::DATA_W-1:0]  entry,
	output logic                                ge,
	output logic signed [sidm_pkg::DATA_W-1:0]  run_min,
	output logic signed [sidm_pkg::DATA_W-1:0]  run_max
);
	import sidm_pkg::*;

	logic signed [DATA_W-1:0] entry_q;
	logic signed [DATA_W-1:0] run_min_q;
	logic signed [DATA_W-1:0] run_max_q;

	// entry: direct write, take the inserted value, or take the left neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (ctrl.load || ctrl.place) begin
			entry_q <= value_in;
		end else if (ctrl.shift) begin
			entry_q <= left_entry;
		end
	end

	// running min/max ripples one cell per cycle down the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_q <= '0;
			run_max_q <= '0;
		end else begin
			run_min_q <= (left_min < entry_q) ? left_min : entry_q;
			run_max_q <= (left_max > entry_q) ? left_max : entry_q;
		end
	end

	// compare against the value being inserted
	assign ge      = (entry_q >= value_in);
	assign entry   = entry_q;
	assign run_min = run_min_q;
	assign run_max = run_max_q;

	`SIDM_ASSERT_SAME(a_cell_cmd_excl, 1'b1, $onehot0({ctrl.load, ctrl.shift, ctrl.place}), "cell got conflicting commands")

endmodule

`default_nettype wire

// ===== hdl/sorted_insert_drop_max.sv =====
// table of signed entries with bounded insert that drops the last entry (the largest while sorted)
//
// Input channel (in_valid/in_ready) takes kind, value, index; output channel
// (out_valid/out_ready) returns result_value, rejected, smallest, largest,
// one result per input transfer, in order.
// Reads and unused kinds answer at the input transfer edge, where the result
// register loads. For loads and inserts the entries change at the transfer
// edge, then the running min/max moves one cell per cycle down the row of
// DEPTH cells, and the result is registered once it has reached the last cell.
// One item is in flight at a time: reads can transfer every cycle, but no item
// is taken until the sweep of a load or insert has ended; in_ready is high only
// while the sequencer is idle and the result register is empty or being
// emptied.
// Reset clears every entry to zero, so the table starts with minimum and
// maximum both zero, and the output register is empty.
// When the receiver stalls, the result stays in the output register and no
// further input transfer is taken until it leaves.
// An insert outside the current min..max is flagged as rejected and leaves
// the table unchanged.
`default_nettype none

`include "sorted_insert_drop_max_defines.svh"

module sorted_insert_drop_max (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [sidm_pkg::KIND_W-1:0]         kind,
	input  logic signed [sidm_pkg::DATA_W-1:0]  value,
	input  logic [sidm_pkg::IDX_W-1:0]          index,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [sidm_pkg::DATA_W-1:0]  result_value,
	output logic                                rejected,
	output logic signed [sidm_pkg::DATA_W-1:0]  smallest,
	output logic signed [sidm_pkg::DATA_W-1:0]  largest
);
	import sidm_pkg::*;

	state_t state_q;
	state_t state_d;
	logic [CNT_W-1:0] cnt_q;

	logic signed [DATA_W-1:0] entry_w [DEPTH];
	logic signed [DATA_W-1:0] min_w   [DEPTH];
	logic signed [DATA_W-1:0] max_w   [DEPTH];
	cell_ctrl_t               ctrl_w  [DEPTH];
	logic [DEPTH-1:0]         ge_vec;
	logic [DEPTH-1:0]         prior_vec;

	logic                     in_xfer;
	logic                     mutating;
	logic                     reject;
	logic                     ins_go;
	logic signed [DATA_W-1:0] rd_val;
	logic signed [DATA_W-1:0] imm_res;
	logic                     out_load;
	logic                     sweep_done;

	logic signed [DATA_W-1:0] res_q;
	logic                     rej_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] result_value_q;
	logic                     rejected_q;
	logic signed [DATA_W-1:0] smallest_q;
	logic signed [DATA_W-1:0] largest_q;

	// row of cells; the first cell is its own left neighbor
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_entry;
		logic signed [DATA_W-1:0] left_min;
		logic signed [DATA_W-1:0] left_max;

		if (i == 0) begin : g_first
			assign left_entry = entry_w[0];
			assign left_min   = entry_w[0];
			assign left_max   = entry_w[0];
		end else begin : g_rest
			assign left_entry = entry_w[i-1];
			assign left_min   = min_w[i-1];
			assign left_max   = max_w[i-1];
		end

		sidm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl_w[i]),
			.value_in   (value),
			.left_entry (left_entry),
			.left_min   (left_min),
			.left_max   (left_max),
			.entry      (entry_w[i]),
			.ge         (ge_vec[i]),
			.run_min    (min_w[i]),
			.run_max    (max_w[i])
		);
	end

	// transfer and bound check against the settled min/max
	assign in_xfer  = in_valid && in_ready;
	assign mutating = (kind == KIND_LOAD) || (kind == KIND_INSERT);
	assign reject   = (kind == KIND_INSERT) &&
	                  ((value < min_w[DEPTH-1]) || (value > max_w[DEPTH-1]));
	assign ins_go   = in_xfer && (kind == KIND_INSERT) && !reject;

	// an earlier cell from index 1 on already holds a value >= the insert
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			prior_vec[i] = |(ge_vec & ((DEPTH'(1) << i) - DEPTH'(1)) & ~DEPTH'(1));
		end
	end

	// cell commands: load by index, shift behind the insert point, place at it
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ctrl_w[i].load  = in_xfer && (kind == KIND_LOAD) &&
			                  (i < (1 << IDX_W)) && (index == IDX_W'(i));
			ctrl_w[i].shift = ins_go && (i != 0) && prior_vec[i];
			ctrl_w[i].place = ins_go && (i != 0) && !prior_vec[i] &&
			                  (ge_vec[i] || (i == DEPTH - 1));
		end
	end

	// read mux over the cells that an index can reach
	always_comb begin
		rd_val = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if ((i < (1 << IDX_W)) && (index == IDX_W'(i))) begin
				rd_val = entry_w[i];
			end
		end
	end

	assign imm_res = (kind == KIND_READ) ? rd_val : '0;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && mutating) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (sweep_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready   = 1'b0;
		out_load   = 1'b0;
		sweep_done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				out_load = in_xfer && !mutating;
			end
			ST_SWEEP: begin
				sweep_done = (cnt_q == CNT_W'(DEPTH));
				out_load   = sweep_done;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// state and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SWEEP) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// insert outcome held while min/max settle
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_q <= ins_go ? entry_w[DEPTH-1] : '0;
			rej_q <= reject;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_value_q <= (state_q == ST_SWEEP) ? res_q : imm_res;
			rejected_q     <= (state_q == ST_SWEEP) ? rej_q : 1'b0;
			smallest_q     <= min_w[DEPTH-1];
			largest_q      <= max_w[DEPTH-1];
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_value_q;
	assign rejected     = rejected_q;
	assign smallest     = smallest_q;
	assign largest      = largest_q;

	`SIDM_ASSERT_NEXT(a_mut_sweeps, in_xfer && mutating, (state_q == ST_SWEEP) && !out_valid_q, "load or insert did not start a sweep")
	`SIDM_ASSERT_NEXT(a_imm_result, in_xfer && !mutating, out_valid_q, "read did not produce a result")
	`SIDM_ASSERT_SAME(a_no_take_in_sweep, state_q == ST_SWEEP, !in_ready, "input taken during sweep")
	`SIDM_ASSERT_SAME(a_min_le_max, out_valid_q, smallest_q <= largest_q, "smallest above largest")

endmodule

`default_nettype wire

// ===== tb/sidm_checker.sv =====
// result checker for the sorted insert block: predicts each result and compares it
`timescale 1ns / 100ps

module sidm_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [sidm_pkg::KIND_W-1:0]         kind,
	input  logic signed [sidm_pkg::DATA_W-1:0]  value,
	input  logic [sidm_pkg::IDX_W-1:0]          index,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic signed [sidm_pkg::DATA_W-1:0]  result_value,
	input  logic                                rejected,
	input  logic signed [sidm_pkg::DATA_W-1:0]  smallest,
	input  logic signed [sidm_pkg::DATA_W-1:0]  largest,
	output int                                  fail_count,
	output int                                  pending,
	output int                                  checked,
	output int                                  rejects
);

	import sidm_pkg::*;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		logic                     rejected;
		logic signed [DATA_W-1:0] smallest;
		logic signed [DATA_W-1:0] largest;
	} item_outcome_t;

	// shadow copy of the table and results still owed by the block
	logic signed [DATA_W-1:0] tab [DEPTH];
	item_outcome_t            outcome_q [$];

	// lowest and highest entry over the whole table, whatever its order
	function automatic logic signed [DATA_W-1:0] tab_bound(input logic want_max);
		logic signed [DATA_W-1:0] m;
		m = tab[0];
		for (int k = 1; k < DEPTH; k++) begin
			if (want_max ? (tab[k] > m) : (tab[k] < m))
				m = tab[k];
		end
		return m;
	endfunction

	// apply one item to the shadow table and work out the result it causes
	function automatic item_outcome_t apply_to_table(
		input logic [KIND_W-1:0]        k_in,
		input logic signed [DATA_W-1:0] v_in,
		input logic [IDX_W-1:0]         i_in
	);
		item_outcome_t            o;
		logic signed [DATA_W-1:0] lo;
		logic signed [DATA_W-1:0] hi;
		int                       pos;
		logic                     found;
		o = '0;
		case (k_in)
			KIND_LOAD: begin
				if (i_in < DEPTH)
					tab[i_in] = v_in;
			end
			KIND_INSERT: begin
				lo = tab_bound(1'b0);
				hi = tab_bound(1'b1);
				if (v_in < lo || v_in > hi) begin
					o.rejected = 1'b1;
				end else begin
					// first entry from index 1 on that is not below the value
					pos = DEPTH - 1;
					found = 1'b0;
					for (int k = 1; k < DEPTH; k++) begin
						if (!found && tab[k] >= v_in) begin
							pos = k;
							found = 1'b1;
						end
					end
					o.result_value = tab[DEPTH-1];
					for (int k = DEPTH - 1; k > pos; k--)
						tab[k] = tab[k-1];
					tab[pos] = v_in;
				end
			end
			KIND_READ: begin
				if (i_in < DEPTH)
					o.result_value = tab[i_in];
			end
			default: ;
		endcase
		o.smallest = tab_bound(1'b0);
		o.largest  = tab_bound(1'b1);
		return o;
	endfunction

	// compare each result transfer, then record what a new input transfer owes
	always @(posedge clk or negedge arst_n) begin : monitor
		item_outcome_t want;
		int            nerr;
		int            nrej;
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++)
				tab[k] = '0;
			outcome_q.delete();
			fail_count <= 0;
			pending    <= 0;
			checked    <= 0;
			rejects    <= 0;
		end else begin
			nerr = 0;
			nrej = 0;
			if (out_valid && out_ready) begin
				if (outcome_q.size() == 0) begin
					$error("result transfer with no item outstanding");
					nerr++;
				end else begin
					want = outcome_q.pop_front();
					if (result_value !== want.result_value) begin
						$error("result_value: expected %0d, actual %0d",
							want.result_value, result_value);
						nerr++;
					end
					if (rejected !== want.rejected) begin
						$error("rejected: expected %0d, actual %0d",
							want.rejected, rejected);
						nerr++;
					end
					if (smallest !== want.smallest) begin
						$error("smallest: expected %0d, actual %0d",
							want.smallest, smallest);
						nerr++;
					end
					if (largest !== want.largest) begin
						$error("largest: expected %0d, actual %0d",
							want.largest, largest);
						nerr++;
					end
					checked <= checked + 1;
				end
			end
			if (in_valid && in_ready) begin
				want = apply_to_table(kind, value, index);
				if (want.rejected)
					nrej = 1;
				outcome_q.push_back(want);
			end
			fail_count <= fail_count + nerr;
			rejects    <= rejects + nrej;
			pending    <= outcome_q.size();
		end
	end

endmodule

// ===== tb/tb_sorted_insert_drop_max.sv =====
// top of the sorted insert testbench: clock, reset, stimulus, watchdog and verdict
`timescale 1ns / 100ps

module tb_sorted_insert_drop_max;

	import sidm_pkg::*;

	localparam logic [KIND_W-1:0]        KIND_UNUSED  = 2'd3;
	localparam logic signed [DATA_W-1:0] MOST_NEG     = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] MOST_POS     = 32'sh7fff_ffff;
	localparam int                       RANDOM_ITEMS = 450;
	localparam int                       IDLE_LIMIT   = 1000;
	localparam int                       TAIL_CYCLES  = 40;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [KIND_W-1:0]        kind = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic [IDX_W-1:0]         index = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [DATA_W-1:0] result_value;
	logic                     rejected;
	logic signed [DATA_W-1:0] smallest;
	logic signed [DATA_W-1:0] largest;

	int fail_count;
	int pending;
	int checked;
	int rejects;

	int   n_sent   = 0;
	int   n_load   = 0;
	int   n_insert = 0;
	int   n_read   = 0;
	int   n_other  = 0;
	int   idle_cycles;
	logic calm = 1'b0;

	// last sorted table loaded, used to aim inserts inside the bounds
	logic signed [DATA_W-1:0] loaded [DEPTH];

	sorted_insert_drop_max u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.value        (value),
		.index        (index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.rejected     (rejected),
		.smallest     (smallest),
		.largest      (largest)
	);

	sidm_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.value        (value),
		.index        (index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.rejected     (rejected),
		.smallest     (smallest),
		.largest      (largest),
		.fail_count   (fail_count),
		.pending      (pending),
		.checked      (checked),
		.rejects      (rejects)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver stalls, none during the calm stretch
	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= 17);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// one input transfer, with random idle cycles ahead of it
	task automatic offer_item(
		input logic [KIND_W-1:0]        k_in,
		input logic signed [DATA_W-1:0] v_in,
		input logic [IDX_W-1:0]         i_in
	);
		calm = (n_sent >= 200 && n_sent < 300);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 17) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k_in;
		value    <= v_in;
		index    <= i_in;
		do
			@(posedge clk);
		while (!in_ready);
		n_sent++;
		case (k_in)
			KIND_LOAD:   n_load++;
			KIND_INSERT: n_insert++;
			KIND_READ:   n_read++;
			default:     n_other++;
		endcase
	endtask

	// table entry drawn wide, narrow (many repeats) or from the extremes
	function automatic logic signed [DATA_W-1:0] rand_entry(input int spread);
		logic signed [DATA_W-1:0] v;
		case (spread)
			0: v = $urandom;
			1: v = $signed($urandom_range(0, 40)) - 20;
			default: begin
				case ($urandom_range(0, 4))
					0: v = MOST_NEG;
					1: v = MOST_POS;
					2: v = '0;
					3: v = -1;
					default: v = $urandom;
				endcase
			end
		endcase
		return v;
	endfunction

	initial begin : stimulus
		logic signed [DATA_W-1:0] v;
		logic signed [DATA_W-1:0] t;
		longint                   span;
		longint unsigned          wide;
		longint                   off;
		int                       r;
		int                       sel;
		int                       j;
		int                       b;
		int                       spread;
		int                       stop_at;

		// reset
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: all-zero table, bounds inclusive on both ends
		offer_item(KIND_READ, '0, '0);
		offer_item(KIND_INSERT, '0, '0);
		offer_item(KIND_INSERT, 1, '0);
		offer_item(KIND_INSERT, -1, '0);
		offer_item(KIND_UNUSED, MOST_POS, 4'hf);
		// extremes of the value range, insert equal to the minimum and to the maximum
		offer_item(KIND_LOAD, MOST_NEG, '0);
		offer_item(KIND_LOAD, MOST_POS, 4'hf);
		offer_item(KIND_INSERT, MOST_NEG, '0);
		offer_item(KIND_LOAD, MOST_POS, 4'hf);
		offer_item(KIND_INSERT, MOST_POS, 4'hf);
		offer_item(KIND_READ, '0, 4'hf);
		offer_item(KIND_READ, '0, '0);
		// unsorted table where no later entry is large enough: value lands last
		offer_item(KIND_LOAD, 1000, '0);
		offer_item(KIND_LOAD, 5, 4'hf);
		offer_item(KIND_INSERT, 500, '0);
		offer_item(KIND_READ, '0, 4'hf);
		// alternating bit patterns
		offer_item(KIND_LOAD, 32'sh5555_5555, 4'd7);
		offer_item(KIND_LOAD, 32'shAAAA_AAAA, 4'd8);
		offer_item(KIND_INSERT, 32'sh1234_5678, 4'd5);
		offer_item(KIND_READ, '0, 4'd7);
		offer_item(KIND_READ, '0, 4'd8);
		offer_item(KIND_INSERT, MOST_NEG, '0);
		offer_item(KIND_UNUSED, $urandom, IDX_W'($urandom));

		// random: mostly a freshly loaded sorted table followed by inserts and reads
		stop_at = n_sent + RANDOM_ITEMS;
		while (n_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 78) begin
				spread = $urandom_range(0, 2);
				for (int k = 0; k < DEPTH; k++)
					loaded[k] = rand_entry(spread);
				for (int a = 1; a < DEPTH; a++) begin
					t = loaded[a];
					b = a;
					while (b > 0 && loaded[b-1] > t) begin
						loaded[b] = loaded[b-1];
						b--;
					end
					loaded[b] = t;
				end
				for (int k = 0; k < DEPTH; k++)
					offer_item(KIND_LOAD, loaded[k], k[IDX_W-1:0]);
				repeat ($urandom_range(6, 14)) begin
					r = $urandom_range(0, 99);
					j = $urandom_range(0, DEPTH - 1);
					if (r < 64) begin
						sel = $urandom_range(0, 99);
						if (sel < 35) begin
							v = loaded[j];
						end else if (sel < 50) begin
							if ($urandom_range(0, 1))
								v = loaded[j] + 1;
							else
								v = loaded[j] - 1;
						end else if (sel < 85) begin
							span = longint'(loaded[DEPTH-1]) - longint'(loaded[0]);
							wide = {$urandom, $urandom};
							off  = wide % (span + 1);
							v    = loaded[0] + off[DATA_W-1:0];
						end else begin
							v = $urandom;
						end
						offer_item(KIND_INSERT, v, IDX_W'($urandom));
					end else if (r < 95) begin
						offer_item(KIND_READ, $urandom, j[IDX_W-1:0]);
					end else begin
						offer_item(KIND_UNUSED, $urandom, IDX_W'($urandom));
					end
				end
			end else begin
				// noise: any kind, any index, table left unsorted
				repeat ($urandom_range(1, 6))
					offer_item(KIND_W'($urandom), rand_entry($urandom_range(0, 2)),
						IDX_W'($urandom));
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// drain outstanding results, then watch for strays
		while (pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d items: %0d loads, %0d inserts, %0d reads, %0d of unused kind",
			n_sent, n_load, n_insert, n_read, n_other);
		$display("%0d results checked, %0d inserts out of bounds, %0d mismatches",
			checked, rejects, fail_count);
		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			if (pending != 0)
				$error("%0d results never arrived", pending);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
